>>> sv/nonpreemptive_priority_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define NPPS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Check that cons holds in the cycle after ante.
`define NPPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> sv/npps_pkg.sv
// Shared types and constants of the priority scheduler.
`timescale 1ns / 1ps
package npps_pkg;
    localparam int DEF_MAX_PROCS = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int TIME_W        = 21;
    localparam int ARR_W         = 16;
    localparam int BURST_W       = 16;
    localparam int PRIO_W        = 8;
    localparam int IDX_OUT_W     = 4;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  job_priority;
        logic               last_job;
    } in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] job_index;
        logic [TIME_W-1:0]    completion_time;
        logic [TIME_W-1:0]    turnaround_time;
        logic [TIME_W-1:0]    waiting_time;
        logic                 last_result;
    } out_t;

    // One queued request: the job and whether it takes a store slot.
    typedef struct packed {
        in_t  job;
        logic keep;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } rec_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_OUT_RD,
        ST_OUT_CALC,
        ST_OUT_WAIT
    } back_state_t;
endpackage

>>> sv/npps_front.sv
// Front end: accept requests and mark those that still fit the job store.
`timescale 1ns / 1ps
module npps_front import npps_pkg::*; #(
    parameter int MAX_PROCS = DEF_MAX_PROCS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_t      s_data,
    input  q_stat_t  q_stat,
    output logic     q_push,
    output q_entry_t q_entry
);
    localparam int CW = $clog2(MAX_PROCS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          fits;

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;
    assign fits    = cnt_reg < CW'(MAX_PROCS);

    assign q_entry.job  = s_data;
    assign q_entry.keep = fits;

    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) begin
            if (s_data.last_job) begin
                cnt_next = '0;
            end else if (fits) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end
endmodule

>>> sv/npps_queue.sv
// Small request queue between front and back end.
`timescale 1ns / 1ps
module npps_queue import npps_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t wr_entry,
    input  logic     pop,
    output q_entry_t head,
    output q_stat_t  stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t      slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    assign head       = slots[rd_ptr_reg];
    assign stat.full  = fill_reg == CW'(DEPTH);
    assign stat.empty = fill_reg == '0;

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end
endmodule

>>> sv/npps_back.sv
// Back end: store jobs, scan for each pick, then emit results in load order.
`timescale 1ns / 1ps
module npps_back import npps_pkg::*; #(
    parameter int MAX_PROCS = DEF_MAX_PROCS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  q_entry_t head,
    input  q_stat_t  q_stat,
    output logic     q_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output out_t     m_data
);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    back_state_t state_reg, state_next;

    rec_t              rec_mem  [MAX_PROCS];
    logic [TIME_W-1:0] comp_mem [MAX_PROCS];
    rec_t              rec_q;
    logic [TIME_W-1:0] comp_q;
    logic [IW-1:0]     rd_addr;

    logic [CW-1:0]        count_reg, picks_reg;
    logic [IW-1:0]        scan_reg, eval_idx_reg, best_idx_reg, out_idx_reg;
    logic                 eval_reg, found_reg, any_reg;
    logic [PRIO_W-1:0]    best_prio_reg;
    logic [BURST_W-1:0]   best_burst_reg;
    logic [ARR_W-1:0]     earliest_reg;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [MAX_PROCS-1:0] done_reg;
    out_t                 out_reg;

    logic scan_last, pick_last, out_last, is_ready, is_pending;
    logic [TIME_W-1:0] ta;

    assign scan_last = CW'(scan_reg) == count_reg - 1'b1;
    assign pick_last = picks_reg == count_reg - 1'b1;
    assign out_last  = CW'(out_idx_reg) == count_reg - 1'b1;
    assign is_pending = !done_reg[eval_idx_reg];
    assign is_ready   = is_pending && (TIME_W'(rec_q.arrival) <= time_reg);
    assign time_next  = time_reg + TIME_W'(best_burst_reg);
    assign ta         = comp_q - TIME_W'(rec_q.arrival);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (!q_stat.empty && head.job.last_job) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (found_reg && pick_last) state_next = ST_OUT_RD;
                else                        state_next = ST_SCAN;
            end
            ST_OUT_RD:   state_next = ST_OUT_CALC;
            ST_OUT_CALC: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (m_ready) state_next = out_last ? ST_LOAD : ST_OUT_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        q_pop   = (state_reg == ST_LOAD) && !q_stat.empty;
        m_valid = state_reg == ST_OUT_WAIT;
        rd_addr = (state_reg == ST_SCAN) ? scan_reg : out_idx_reg;
    end

    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (q_pop && head.keep) begin
            rec_mem[count_reg[IW-1:0]] <= '{arrival: head.job.arrival_time,
                                            burst:   head.job.burst_time,
                                            prio:    head.job.job_priority};
        end
        rec_q <= rec_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE && found_reg) begin
            comp_mem[best_idx_reg] <= time_next;
        end
        comp_q <= comp_mem[out_idx_reg];
    end

    // Scan datapath: evaluate the record read in the previous cycle.
    always_ff @(posedge aclk) begin
        eval_idx_reg <= scan_reg;
        if (eval_reg) begin
            if (is_ready && (!found_reg || rec_q.prio < best_prio_reg)) begin
                found_reg      <= 1'b1;
                best_idx_reg   <= eval_idx_reg;
                best_prio_reg  <= rec_q.prio;
                best_burst_reg <= rec_q.burst;
            end
            if (is_pending && (!any_reg || rec_q.arrival < earliest_reg)) begin
                any_reg      <= 1'b1;
                earliest_reg <= rec_q.arrival;
            end
        end
        if (state_reg == ST_SCAN) begin
            scan_reg <= scan_reg + 1'b1;
        end
        if ((q_pop && head.job.last_job) || state_reg == ST_DECIDE) begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        if (state_reg == ST_OUT_CALC) begin
            out_reg.job_index       <= IDX_OUT_W'(out_idx_reg);
            out_reg.completion_time <= comp_q;
            out_reg.turnaround_time <= ta;
            out_reg.waiting_time    <= ta - TIME_W'(rec_q.burst);
            out_reg.last_result     <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            picks_reg   <= '0;
            out_idx_reg <= '0;
            time_reg    <= '0;
            done_reg    <= '0;
            eval_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            eval_reg  <= state_reg == ST_SCAN;
            if (q_pop && head.keep) begin
                count_reg <= count_reg + 1'b1;
            end
            if (q_pop && head.job.last_job) begin
                picks_reg   <= '0;
                out_idx_reg <= '0;
                time_reg    <= '0;
            end
            if (state_reg == ST_DECIDE) begin
                if (found_reg) begin
                    time_reg               <= time_next;
                    done_reg[best_idx_reg] <= 1'b1;
                    picks_reg              <= picks_reg + 1'b1;
                end else begin
                    time_reg <= TIME_W'(earliest_reg);
                end
            end
            if (state_reg == ST_OUT_WAIT && m_ready) begin
                out_idx_reg <= out_idx_reg + 1'b1;
                if (out_last) begin
                    count_reg <= '0;
                    done_reg  <= '0;
                end
            end
        end
    end
endmodule

>>> sv/nonpreemptive_priority_scheduler.sv
// Top level of the non-preemptive priority scheduler.
//
//  channel  ports                     payload  moves
//  input    s_valid s_ready s_data    in_t     one job request
//  result   m_valid m_ready m_data    out_t    one per-job result
//
//  A request enters the queue when accepted; the back end loads one per cycle while in its load state.
//  Each pick scans all n stored jobs through the job memory, then drains and
//  decides; when no job is ready the clock idles forward and the scan repeats.
//  Each result is read, computed and then held until m_ready takes it.
//  Reset (aresetn, synchronous) empties the queue and the job set.
//  The front keeps accepting into the queue while the back end schedules, until the queue is full.
`timescale 1ns / 1ps
module nonpreemptive_priority_scheduler import npps_pkg::*; #(
    parameter int MAX_PROCS = DEF_MAX_PROCS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);
    `include "nonpreemptive_priority_scheduler_assert.svh"

    q_entry_t q_wr_entry, q_head;
    q_stat_t  q_stat;
    logic     q_push, q_pop;

    // Classify each request: drop its store write once the set is full.
    npps_front #(.MAX_PROCS(MAX_PROCS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (q_wr_entry)
    );

    // Hold requests while the back end is busy with a schedule.
    npps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // Load jobs, schedule on the final request, then drain results.
    npps_back #(.MAX_PROCS(MAX_PROCS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `NPPS_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, q_pop, !q_stat.empty)
    `NPPS_ASSERT_NEXT(a_last_ends_set, aclk, aresetn,
        m_valid && m_ready && m_data.last_result, !m_valid)
    `NPPS_ASSERT_NOW(a_full_stalls, aclk, aresetn, q_stat.full, !s_ready && !q_push)
endmodule

>>> tb/nonpreemptive_priority_scheduler_tb.sv
// Self-checking testbench for the non-preemptive priority scheduler.
`timescale 1ns / 1ps

// Tracks the job set being loaded and computes the per-job results of each schedule.
class job_set_checker;
    localparam int NJOBS = npps_pkg::DEF_MAX_PROCS;
    localparam int TW    = npps_pkg::TIME_W;

    logic [15:0]   arr_q[NJOBS];
    logic [15:0]   burst_q[NJOBS];
    logic [7:0]    prio_q[NJOBS];
    int            job_count;
    npps_pkg::out_t expected_results[$];
    int            errors;
    int            results_seen;
    int            sets_done;
    int            jobs_dropped;

    function new();
        job_count    = 0;
        errors       = 0;
        results_seen = 0;
        sets_done    = 0;
        jobs_dropped = 0;
    endfunction

    // Build the schedule of the stored set and queue one result per job.
    function void schedule_set();
        logic [TW-1:0] now;
        logic [TW-1:0] fin[NJOBS];
        logic [TW-1:0] ta;
        bit            done[NJOBS];
        bit            found;
        int            pick;
        logic [15:0]   earliest;
        npps_pkg::out_t r;
        for (int j = 0; j < NJOBS; j++) done[j] = 0;
        now = '0;
        for (int k = 0; k < job_count; k++) begin
            found = 0;
            pick  = 0;
            for (int j = 0; j < job_count; j++) begin
                if (!done[j] && arr_q[j] <= now &&
                    (!found || prio_q[j] < prio_q[pick])) begin
                    pick  = j;
                    found = 1;
                end
            end
            if (!found) begin
                // nothing ready: idle the clock to the earliest pending arrival
                earliest = 16'hffff;
                for (int j = 0; j < job_count; j++)
                    if (!done[j] && arr_q[j] < earliest) earliest = arr_q[j];
                now = TW'(earliest);
                for (int j = 0; j < job_count; j++) begin
                    if (!done[j] && arr_q[j] <= now &&
                        (!found || prio_q[j] < prio_q[pick])) begin
                        pick  = j;
                        found = 1;
                    end
                end
            end
            now       = now + TW'(burst_q[pick]);
            fin[pick] = now;
            done[pick] = 1;
        end
        for (int k = 0; k < job_count; k++) begin
            ta = fin[k] - TW'(arr_q[k]);
            r.job_index       = 4'(k);
            r.completion_time = fin[k];
            r.turnaround_time = ta;
            r.waiting_time    = ta - TW'(burst_q[k]);
            r.last_result     = (k + 1 == job_count);
            expected_results.push_back(r);
        end
        job_count = 0;
        sets_done++;
    endfunction

    function void note_request(npps_pkg::in_t j);
        if (job_count < NJOBS) begin
            arr_q[job_count]   = j.arrival_time;
            burst_q[job_count] = j.burst_time;
            prio_q[job_count]  = j.job_priority;
            job_count++;
        end else begin
            jobs_dropped++;
        end
        if (j.last_job) schedule_set();
    endfunction

    function void check_result(npps_pkg::out_t got);
        npps_pkg::out_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, got);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.job_index !== want.job_index ||
            got.completion_time !== want.completion_time ||
            got.turnaround_time !== want.turnaround_time ||
            got.waiting_time !== want.waiting_time ||
            got.last_result !== want.last_result) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            errors++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module nonpreemptive_priority_scheduler_tb;
    import npps_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    job_set_checker checker_h;
    bit quiet;          // no idling on either side while set
    bit hold_request;   // ask the receiver for one long hold-off
    bit hold_done;      // the long hold-off has been requested once
    int requests_sent;
    int stall_cycles;

    nonpreemptive_priority_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    // Check every accepted result and watch for a hung block.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) checker_h.check_result(m_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("nonpreemptive_priority_scheduler_tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 0;
                for (int c = 0; c < 600; c++) @(negedge aclk);
                hold_request = 0;
            end else begin
                m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
            end
        end
    end

    // Offer one request and hold it until accepted; valid stays high afterwards
    // so a following send never drops and raises it in the same step.
    task automatic send_job(in_t j);
        if (!quiet && $urandom_range(99) < 25) begin
            @(negedge aclk);
            s_valid <= 0;
            repeat ($urandom_range(6)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1;
        s_data  <= j;
        do @(posedge aclk); while (!s_ready);
        checker_h.note_request(j);
        requests_sent++;
    endtask

    task automatic send_one(int arr, int burst, int prio, bit last);
        in_t j;
        j.arrival_time = 16'(arr);
        j.burst_time   = 16'(burst);
        j.job_priority = 8'(prio);
        j.last_job     = last;
        send_job(j);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 0;
        while (checker_h.pending() != 0) @(posedge aclk);
    endtask

    // Random set: n requests, arrivals sorted unless shuffled, final one marked last.
    task automatic send_random_set(int n, bit shuffled);
        int arr;
        int burst;
        int prio;
        arr = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(30);
        for (int i = 0; i < n; i++) begin
            if (shuffled) arr = $urandom_range(65535);
            else if (i > 0) arr = arr + (($urandom_range(4) == 0) ?
                                          $urandom_range(300) : $urandom_range(8));
            if (arr > 65535) arr = 65535;
            burst = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(20);
            prio  = ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(3);
            send_one(arr, burst, prio, i == n - 1);
        end
    endtask

    initial begin
        int n;
        checker_h     = new();
        quiet         = 0;
        hold_request  = 0;
        hold_done     = 0;
        requests_sent = 0;
        stall_cycles  = 0;
        aresetn = 0;
        s_valid = 0;
        s_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // single job at the top of every field
        send_one(65535, 65535, 255, 1);
        // zero bursts and a priority tie broken by load order
        send_one(0, 0, 0, 0);
        send_one(0, 0, 0, 0);
        send_one(5, 3, 0, 1);
        // idle gap before the second arrival, priorities reversed
        send_one(0, 2, 200, 0);
        send_one(1000, 4, 1, 0);
        send_one(1000, 1, 0, 1);
        // unsorted arrivals
        send_one(50, 5, 2, 0);
        send_one(10, 7, 9, 0);
        send_one(30, 1, 0, 1);
        wait_drained();
        // overfull set: the last two requests are dropped, the set still runs
        for (int i = 0; i < 18; i++)
            send_one(i, $urandom_range(65535), $urandom_range(255), i == 17);

        // random sets, with a quiet stretch and one long receiver hold-off
        while (requests_sent < 340) begin
            quiet = (requests_sent > 150 && requests_sent < 230);
            if (requests_sent > 250 && !hold_done) begin
                hold_request = 1;
                hold_done    = 1;
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
            send_random_set(n, $urandom_range(7) == 0);
            if ($urandom_range(9) == 0) wait_drained();
        end
        quiet = 0;

        wait_drained();
        repeat (100) @(posedge aclk);
        $display("ran %0d requests in %0d sets, %0d results checked, %0d dropped when full",
                 requests_sent, checker_h.sets_done, checker_h.results_seen,
                 checker_h.jobs_dropped);
        if (checker_h.errors == 0 && checker_h.pending() == 0) begin
            $display("nonpreemptive_priority_scheduler_tb: done, clean");
        end else begin
            $display("nonpreemptive_priority_scheduler_tb: done, errors");
        end
        $finish;
    end
endmodule
